### sv/ccts_pkg.sv
// ----------------------------------------------------------------------------
// ccts_pkg - shared types and constants for the cycle counter time split
// Widths of the serial divider and the command that launches one division.
// ----------------------------------------------------------------------------
package ccts_pkg;

    localparam int CLK_W   = 10;          // clock_mhz register
    localparam int SMP_W   = 32;          // counter sample
    localparam int EXT_W   = 64;          // extended cycle count
    localparam int QUOT_W  = 45;          // widest quotient (whole seconds)
    localparam int REM_W   = 30;          // cycles per second fit in 30 bits
    localparam int PMS_W   = 20;          // cycles per millisecond
    localparam int PART_W  = 10;          // milli / micro parts
    localparam int STEP_W  = 6;

    localparam logic [CLK_W-1:0]  CLOCK_MHZ_RST = CLK_W'(168);
    localparam logic [PMS_W-1:0]  CYC_PER_S_MHZ  = PMS_W'(1000000);
    localparam logic [CLK_W-1:0]  CYC_PER_MS_MHZ = CLK_W'(1000);

    // Seconds quotient: the top 19 bits of the count are below any divisor.
    localparam logic [STEP_W-1:0] SEC_STEPS = STEP_W'(QUOT_W);
    // Sub-splits: quotient is below 1024, so only 10 steps are needed.
    localparam logic [STEP_W-1:0] SUB_STEPS = STEP_W'(PART_W);

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_cmd;

endpackage

### sv/ccts_div.sv
// ----------------------------------------------------------------------------
// ccts_div - bit-serial restoring divider
// One quotient bit per cycle. The dividend sits left aligned in a shift
// register; quotient bits enter at the bottom as dividend bits leave the top.
// ----------------------------------------------------------------------------
module ccts_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ccts_pkg::t_div_cmd            i_cmd,
    input  logic [ccts_pkg::REM_W-1:0]    i_rem_init,
    input  logic [ccts_pkg::QUOT_W-1:0]   i_dividend,
    input  logic [ccts_pkg::REM_W-1:0]    i_den,
    output logic                          o_busy,
    output logic [ccts_pkg::QUOT_W-1:0]   o_quot,
    output logic [ccts_pkg::REM_W-1:0]    o_rem
);
    import ccts_pkg::*;

    logic [STEP_W-1:0] r_cnt;
    logic [REM_W-1:0]  r_rem, r_den, n_rem;
    logic [QUOT_W-1:0] r_shf;
    logic [REM_W+1:0]  w_trial;

    always_comb begin
        w_trial = {1'b0, r_rem, r_shf[QUOT_W-1]} - {2'b0, r_den};
        if (w_trial[REM_W+1]) begin
            n_rem = {r_rem[REM_W-2:0], r_shf[QUOT_W-1]};
        end else begin
            n_rem = w_trial[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.start) begin
            r_cnt <= i_cmd.steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_rem_init;
            r_shf <= i_dividend;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_shf <= {r_shf[QUOT_W-2:0], ~w_trial[REM_W+1]};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_shf;
    assign o_rem  = r_rem;

endmodule

### sv/cycle_counter_time_split.sv
// ----------------------------------------------------------------------------
// cycle_counter_time_split - 64-bit extension and time split of a cycle counter
// Tracks wraps of a 32-bit counter and splits the count into s / ms / us.
// ----------------------------------------------------------------------------
// One word in, one word out. A sample below the last one kept counts a wrap;
// the extended count is {wraps, sample}. Seconds, milliseconds and
// microseconds come from a single bit-serial divider run three times
// (45 + 10 + 10 steps); one word is in work at a time.
// The input is taken again as soon as the result sits in the output register.
// clock_mhz of zero is used as 1 MHz. Write clock_mhz only while idle.
module cycle_counter_time_split (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ccts_pkg::CLK_W-1:0]     i_cfg_clock_mhz,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ccts_pkg::SMP_W-1:0]     i_counter_sample,
    input  logic [ccts_pkg::SMP_W-1:0]     i_earlier_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ccts_pkg::EXT_W-1:0]     o_extended_cycles,
    output logic [ccts_pkg::QUOT_W-1:0]    o_whole_seconds,
    output logic [ccts_pkg::PART_W-1:0]    o_milli_part,
    output logic [ccts_pkg::PART_W-1:0]    o_micro_part,
    output logic [ccts_pkg::SMP_W-1:0]     o_delta_cycles
);
    import ccts_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_SEC  = 3'd2;
    localparam logic [2:0] S_MS   = 3'd3;
    localparam logic [2:0] S_US   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CLK_W-1:0]  r_clock_mhz, r_mhz, w_mhz;
    logic [SMP_W-1:0]  r_wrap, r_prev, n_wrap, r_delta;
    logic [EXT_W-1:0]  r_ext;
    logic [REM_W-1:0]  r_per_s;
    logic [PMS_W-1:0]  r_per_ms;
    logic [QUOT_W-1:0] r_secs;
    logic [PART_W-1:0] r_ms;
    logic              w_in_acc, w_out_free, w_done;

    t_div_cmd          w_cmd;
    logic [REM_W-1:0]  w_rem_init, w_den, w_div_rem;
    logic [QUOT_W-1:0] w_dividend, w_div_quot;
    logic              w_div_busy;

    logic              r_out_valid;
    logic [EXT_W-1:0]  r_out_ext;
    logic [QUOT_W-1:0] r_out_secs;
    logic [PART_W-1:0] r_out_ms, r_out_us;
    logic [SMP_W-1:0]  r_out_delta;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_mhz      = (r_clock_mhz == '0) ? CLK_W'(1) : r_clock_mhz;
    assign n_wrap     = (i_counter_sample < r_prev) ? r_wrap + SMP_W'(1) : r_wrap;

    // divider command per phase; the sub-splits preload the upper remainder bits
    always_comb begin
        w_cmd      = '0;
        w_rem_init = '0;
        w_dividend = '0;
        w_den      = '0;
        w_done     = 1'b0;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_PREP;
            end
            S_PREP: begin
                w_cmd      = '{start: 1'b1, steps: SEC_STEPS};
                w_rem_init = REM_W'(r_ext[EXT_W-1:QUOT_W]);
                w_dividend = r_ext[QUOT_W-1:0];
                w_den      = r_per_s;
                n_state    = S_SEC;
            end
            S_SEC: begin
                if (!w_div_busy) begin
                    w_cmd      = '{start: 1'b1, steps: SUB_STEPS};
                    w_rem_init = REM_W'(w_div_rem[REM_W-1:PART_W]);
                    w_dividend = {w_div_rem[PART_W-1:0], (QUOT_W-PART_W)'(0)};
                    w_den      = REM_W'(r_per_ms);
                    n_state    = S_MS;
                end
            end
            S_MS: begin
                if (!w_div_busy) begin
                    w_cmd      = '{start: 1'b1, steps: SUB_STEPS};
                    w_rem_init = REM_W'(w_div_rem[REM_W-1:PART_W]);
                    w_dividend = {w_div_rem[PART_W-1:0], (QUOT_W-PART_W)'(0)};
                    w_den      = REM_W'(r_mhz);
                    n_state    = S_US;
                end
            end
            S_US: begin
                if (!w_div_busy && w_out_free) begin
                    w_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    ccts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_rem_init (w_rem_init),
        .i_dividend (w_dividend),
        .i_den      (w_den),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clock_mhz <= CLOCK_MHZ_RST;
            r_wrap      <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_clock_mhz <= i_cfg_clock_mhz;
            if (w_in_acc) begin
                r_wrap <= n_wrap;
                r_prev <= i_counter_sample;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ext    <= {n_wrap, i_counter_sample};
            r_delta  <= i_counter_sample - i_earlier_sample;
            r_mhz    <= w_mhz;
            r_per_s  <= REM_W'({{(REM_W-CLK_W){1'b0}}, w_mhz} * {{(REM_W-PMS_W){1'b0}}, CYC_PER_S_MHZ});
            r_per_ms <= PMS_W'({{(PMS_W-CLK_W){1'b0}}, w_mhz} * {{(PMS_W-CLK_W){1'b0}}, CYC_PER_MS_MHZ});
        end
        if (r_state == S_SEC && !w_div_busy) r_secs <= w_div_quot;
        if (r_state == S_MS && !w_div_busy)  r_ms   <= w_div_quot[PART_W-1:0];
        if (w_done) begin
            r_out_ext   <= r_ext;
            r_out_secs  <= r_secs;
            r_out_ms    <= r_ms;
            r_out_us    <= w_div_quot[PART_W-1:0];
            r_out_delta <= r_delta;
        end
    end

    assign o_cfg_ready       = (r_state == S_IDLE);
    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_extended_cycles = r_out_ext;
    assign o_whole_seconds   = r_out_secs;
    assign o_milli_part      = r_out_ms;
    assign o_micro_part      = r_out_us;
    assign o_delta_cycles    = r_out_delta;

endmodule

### sv/ccts_chk.sv
// ----------------------------------------------------------------------------
// ccts_chk - port-level checks for the cycle counter time split
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module ccts_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [ccts_pkg::EXT_W-1:0]     o_extended_cycles,
    input  logic [ccts_pkg::PART_W-1:0]    o_milli_part,
    input  logic [ccts_pkg::PART_W-1:0]    o_micro_part
);
    import ccts_pkg::*;

    // one word in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a word is in work");

    // sub-second splits never reach 1000
    a_parts_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_milli_part < PART_W'(1000) && o_micro_part < PART_W'(1000)))
        else $error("milli or micro part out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_extended_cycles))
        else $error("output word changed while stalled");

endmodule

bind cycle_counter_time_split ccts_chk u_ccts_chk (.*);
